>>> sv/first_fit_heap_allocator_defines.svh
// assertion macros for the allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// implication checked on every edge outside reset
`define FFHA_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define FFHA_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

>>> sv/ffha_pkg.sv
package ffha_pkg;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_STATS = 2'd2;
    localparam logic [1:0] CMD_RSVD  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [2:0] ST_NO_MEM    = 3'd2;
    localparam logic [2:0] ST_BAD_PTR   = 3'd3;
    localparam logic [2:0] ST_DBL_FREE  = 3'd4;

    localparam int OFF_W = 18;
    localparam int SZ_W  = 19;
    localparam int CNT_W = 7;

    // one table entry
    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [OFF_W-1:0] payload;
        logic             busy;
    } entry_t;

    // what every cell does in a cycle
    localparam logic [1:0] SH_HOLD  = 2'd0;
    localparam logic [1:0] SH_RIGHT = 2'd1; // take the left neighbour
    localparam logic [1:0] SH_LEFT  = 2'd2; // take the right neighbour

    typedef struct packed {
        logic [1:0] shift;
    } cell_ctl_t;

endpackage

>>> sv/ffha_cell.sv
module ffha_cell
    import ffha_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter logic [IDX_W-1:0] MY_IDX = '0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctl_t        ctl,
    input  logic [IDX_W-1:0] lo_idx,   // cells at or above this index shift
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  entry_t           wr_data,
    input  entry_t           left_in,
    input  entry_t           right_in,
    output entry_t           q
);

    entry_t q_reg;
    entry_t q_next;

    always_comb
    begin
        q_next = q_reg;
        if (MY_IDX >= lo_idx)
        begin
            case (ctl.shift)
                SH_RIGHT: q_next = left_in;
                SH_LEFT:  q_next = right_in;
                default:  q_next = q_reg;
            endcase
        end
        if (wr_en && wr_idx == MY_IDX)
            q_next = wr_data;
    end

    // whole entry clears at reset, entry zero is loaded right after
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg <= '0;
        else
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

>>> sv/ffha_table.sv
module ffha_table
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS = 64,
    parameter int IDX_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctl_t        ctl,
    input  logic [IDX_W-1:0] lo_idx,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  entry_t           wr_data,
    input  logic [IDX_W-1:0] rd_idx,
    output entry_t           rd_data
);

    entry_t cells [MAX_BLOCKS];
    entry_t rd_reg;

    for (genvar g = 0; g < MAX_BLOCKS; g++)
    begin : g_cell
        entry_t l_in;
        entry_t r_in;
        if (g == 0)
        begin : g_first
            assign l_in = cells[g];
        end
        else
        begin : g_mid
            assign l_in = cells[g-1];
        end
        if (g == MAX_BLOCKS - 1)
        begin : g_last
            assign r_in = cells[g];
        end
        else
        begin : g_nrm
            assign r_in = cells[g+1];
        end
        ffha_cell #(.IDX_W(IDX_W), .MY_IDX(IDX_W'(g))) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .lo_idx   (lo_idx),
            .wr_en    (wr_en),
            .wr_idx   (wr_idx),
            .wr_data  (wr_data),
            .left_in  (l_in),
            .right_in (r_in),
            .q        (cells[g])
        );
    end

    // read data arrives in the cycle after the address
    always_ff @(posedge clk)
    begin
        rd_reg <= cells[rd_idx];
    end

    assign rd_data = rd_reg;

endmodule

>>> sv/first_fit_heap_allocator.sv
// first fit heap allocator
// s_axis carries one request: command, request size and the payload offset to
// free. m_axis carries one answer per request: status, granted offset and the
// statistics fields (zero unless the command reads statistics).
// the block table is a row of cells in address order; a request walks the row
// one entry a cycle; an insert or a removal moves the row by one place. the
// next request can be taken once the answer is loaded.
// one request is in work at a time; s_axis_tready is low from acceptance until
// the answer has been loaded into the output register.
// a held answer waits in the output register while m_axis_tready is low; the
// next request can be taken meanwhile, its answer waits behind it and further
// requests are held off until the output register frees.
// reset (rst_n low) clears the row; entry zero is loaded with a single free
// block spanning the arena minus one header in the init state after reset.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_KB      = 256,
    parameter int HEADER_BYTES = 20,
    parameter int ALIGN_BYTES  = 8,
    parameter int MAX_BLOCKS   = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[1:0], request_size[20:2], payload_offset[38:21], zero fill
    input  logic [39:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], granted_offset[20:3], used_sum[39:21], free_sum[58:40],
    // blocks_in_use[65:59], free_count[72:66], block_total[79:73],
    // largest_hole[98:80], zero fill
    output logic [103:0] m_axis_tdata
);

`include "first_fit_heap_allocator_defines.svh"

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int BC_W   = $clog2(MAX_BLOCKS + 1);
    localparam int ARENA  = HEAP_KB * 1024;
    localparam int WIDE_W = 21;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_ALLOC = 4'd2;
    localparam logic [3:0] S_SPLIT = 4'd3;
    localparam logic [3:0] S_FREE  = 4'd4;
    localparam logic [3:0] S_NEXT  = 4'd5;
    localparam logic [3:0] S_PREV  = 4'd6;
    localparam logic [3:0] S_PREVM = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_INIT  = 4'd9;
    localparam logic [3:0] S_NEXTM = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [WIDE_W-1:0] need_reg, need_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [BC_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]  hit_reg, hit_next;
    entry_t            ent_reg, ent_next;
    logic [2:0]        status_reg, status_next;
    logic [OFF_W-1:0]  granted_reg, granted_next;
    logic [SZ_W-1:0]   used_reg, used_next, freeb_reg, freeb_next, big_reg, big_next;
    logic [CNT_W-1:0]  nu_reg, nu_next, nf_reg, nf_next;
    logic              res_ok_reg, res_ok_next;
    logic              out_valid_reg;
    logic [103:0]      out_data_reg;

    cell_ctl_t         ctl;
    logic [IDX_W-1:0]  lo_idx, rd_idx, wr_idx;
    logic              wr_en;
    entry_t            wr_data, rd_data;

    ffha_table #(.MAX_BLOCKS(MAX_BLOCKS), .IDX_W(IDX_W)) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .lo_idx  (lo_idx),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    logic             in_acc;
    logic             last_idx;
    logic [WIDE_W-1:0] pay_w, rest_w;
    logic [OFF_W-1:0]  ptr_w;

    assign s_axis_tready = (state_reg == S_IDLE) && !res_ok_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign last_idx      = ({1'b0, idx_reg} + 1'b1) >= (IDX_W+1)'(count_reg);
    assign pay_w         = WIDE_W'(rd_data.payload);
    assign rest_w        = pay_w - need_reg;
    assign ptr_w         = rd_data.start + OFF_W'(HEADER_BYTES);

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        need_next    = need_reg;
        off_next     = off_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        hit_next     = hit_reg;
        ent_next     = ent_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        used_next    = used_reg;
        freeb_next   = freeb_reg;
        big_next     = big_reg;
        nu_next      = nu_reg;
        nf_next      = nf_reg;
        res_ok_next  = res_ok_reg;
        ctl.shift    = SH_HOLD;
        lo_idx       = '0;
        rd_idx       = idx_reg;
        wr_en        = 1'b0;
        wr_idx       = idx_reg;
        wr_data      = ent_reg;

        if (res_ok_reg && !(out_valid_reg && !m_axis_tready))
            res_ok_next = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                wr_en           = 1'b1;
                wr_idx          = '0;
                wr_data.start   = '0;
                wr_data.payload = OFF_W'(ARENA - HEADER_BYTES);
                wr_data.busy    = 1'b0;
                state_next      = S_IDLE;
            end
            S_IDLE:
            begin
                // fetch entry zero for the scan
                rd_idx = '0;
                if (in_acc)
                begin
                    cmd_next    = s_axis_tdata[1:0];
                    need_next   = ((WIDE_W'(s_axis_tdata[20:2]) + WIDE_W'(ALIGN_BYTES - 1))
                                   / WIDE_W'(ALIGN_BYTES)) * WIDE_W'(ALIGN_BYTES);
                    off_next    = s_axis_tdata[38:21];
                    idx_next    = '0;
                    status_next = ST_OK;
                    granted_next = '0;
                    used_next   = '0;
                    freeb_next  = '0;
                    big_next    = '0;
                    nu_next     = '0;
                    nf_next     = '0;
                    state_next  = S_DONE;
                    case (s_axis_tdata[1:0])
                        CMD_ALLOC:
                        begin
                            if (s_axis_tdata[20:2] == '0)
                                status_next = ST_ZERO_SIZE;
                            else
                                state_next = S_SCAN;
                        end
                        CMD_FREE:
                        begin
                            if (s_axis_tdata[38:21] != '0)
                                state_next = S_SCAN;
                        end
                        CMD_STATS: state_next = S_SCAN;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                rd_idx   = idx_reg + 1'b1;
                case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (!rd_data.busy && pay_w >= need_reg)
                        begin
                            hit_next   = idx_reg;
                            ent_next   = rd_data;
                            state_next = S_ALLOC;
                        end
                        else if (last_idx)
                        begin
                            status_next = ST_NO_MEM;
                            state_next  = S_DONE;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (ptr_w == off_reg && {1'b0, rd_data.start} +
                            (OFF_W+1)'(HEADER_BYTES) == {1'b0, off_reg})
                        begin
                            hit_next = idx_reg;
                            ent_next = rd_data;
                            if (!rd_data.busy)
                            begin
                                status_next = ST_DBL_FREE;
                                state_next  = S_DONE;
                            end
                            else
                                state_next = S_FREE;
                        end
                        else if (last_idx)
                        begin
                            status_next = ST_BAD_PTR;
                            state_next  = S_DONE;
                        end
                    end
                    default:
                    begin
                        if (rd_data.busy)
                        begin
                            used_next = used_reg + SZ_W'(rd_data.payload);
                            nu_next   = nu_reg + 1'b1;
                        end
                        else
                        begin
                            freeb_next = freeb_reg + SZ_W'(rd_data.payload);
                            nf_next    = nf_reg + 1'b1;
                            if (SZ_W'(rd_data.payload) > big_reg)
                                big_next = SZ_W'(rd_data.payload);
                        end
                        if (last_idx)
                            state_next = S_DONE;
                    end
                endcase
            end
            S_ALLOC:
            begin
                granted_next = ent_reg.start + OFF_W'(HEADER_BYTES);
                if (WIDE_W'(ent_reg.payload) - need_reg >=
                        WIDE_W'(HEADER_BYTES + ALIGN_BYTES) &&
                    count_reg < BC_W'(MAX_BLOCKS))
                begin
                    // open a slot above the hit entry
                    ctl.shift  = SH_RIGHT;
                    lo_idx     = hit_reg + 1'b1;
                    state_next = S_SPLIT;
                end
                else
                begin
                    wr_en        = 1'b1;
                    wr_idx       = hit_reg;
                    wr_data.busy = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_SPLIT:
            begin
                wr_en           = 1'b1;
                wr_idx          = hit_reg + 1'b1;
                wr_data.start   = ent_reg.start + OFF_W'(HEADER_BYTES) + OFF_W'(need_reg);
                wr_data.payload = OFF_W'(WIDE_W'(ent_reg.payload) - need_reg
                                         - WIDE_W'(HEADER_BYTES));
                wr_data.busy    = 1'b0;
                ent_next.payload = OFF_W'(need_reg);
                ent_next.busy    = 1'b1;
                count_next      = count_reg + 1'b1;
                state_next      = S_NEXTM;
                idx_next        = hit_reg;
                // hit entry updated in next cycle
                ent_next.start  = ent_reg.start;
            end
            S_NEXTM:
            begin
                wr_en      = 1'b1;
                wr_idx     = hit_reg;
                wr_data    = ent_reg;
                state_next = S_DONE;
            end
            S_FREE:
            begin
                // next neighbour was fetched during the last scan step
                ent_next.busy = 1'b0;
                if (({1'b0, hit_reg} + 1'b1) < (IDX_W+1)'(count_reg) && !rd_data.busy)
                begin
                    ent_next.payload = ent_reg.payload + OFF_W'(HEADER_BYTES) + rd_data.payload;
                    ctl.shift  = SH_LEFT;
                    lo_idx     = hit_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                // previous neighbour is untouched by the merge above
                rd_idx     = hit_reg - 1'b1;
                wr_en      = 1'b1;
                wr_idx     = hit_reg;
                wr_data    = ent_reg;
                state_next = S_PREV;
            end
            S_PREV:
            begin
                if (hit_reg != '0 && !rd_data.busy)
                begin
                    ent_next         = rd_data;
                    ent_next.payload = rd_data.payload + OFF_W'(HEADER_BYTES) + ent_reg.payload;
                    ctl.shift  = SH_LEFT;
                    lo_idx     = hit_reg;
                    count_next = count_reg - 1'b1;
                    hit_next   = hit_reg - 1'b1;
                    state_next = S_PREVM;
                end
                else
                    state_next = S_DONE;
            end
            S_PREVM:
            begin
                wr_en      = 1'b1;
                wr_idx     = hit_reg;
                wr_data    = ent_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!res_ok_reg)
                begin
                    res_ok_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            count_reg     <= BC_W'(1);
            res_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= CMD_ALLOC;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cmd_reg    <= cmd_next;
            res_ok_reg <= res_ok_next;
            if (res_ok_reg && !(out_valid_reg && !m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg    <= need_next;
        off_reg     <= off_next;
        idx_reg     <= idx_next;
        hit_reg     <= hit_next;
        ent_reg     <= ent_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        used_reg    <= used_next;
        freeb_reg   <= freeb_next;
        big_reg     <= big_next;
        nu_reg      <= nu_next;
        nf_reg      <= nf_next;
        if (res_ok_reg && !(out_valid_reg && !m_axis_tready))
        begin
            out_data_reg <= {5'd0, big_reg,
                             (cmd_reg == CMD_STATS) ? CNT_W'(count_reg) : {CNT_W{1'b0}},
                             nf_reg, nu_reg, freeb_reg, used_reg,
                             (status_reg == ST_OK && cmd_reg == CMD_ALLOC) ?
                                 granted_reg : {OFF_W{1'b0}},
                             status_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `FFHA_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1,
        count_reg >= BC_W'(1) && count_reg <= BC_W'(MAX_BLOCKS), "block count out of range")
    `FFHA_ASSERT_IMP(a_busy_no_accept, clk, rst_n, state_reg != S_IDLE,
        !s_axis_tready, "request taken while busy")
    `FFHA_ASSERT_NEXT(a_split_grows, clk, rst_n, state_reg == S_SPLIT,
        count_reg == $past(count_reg) + 1'b1, "split did not add an entry")

endmodule
